// ===== src/pbrf_pkg.sv =====
// shared types and constants for the point box removal filter
`default_nettype none
package pbrf_pkg;

  localparam int unsigned MAX_BOXES = 64;
  localparam int unsigned SLOT_W    = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned EXT_W     = 31;
  localparam int unsigned TRIG_W    = 16;
  localparam int unsigned DIST_W    = COORD_W + 2;
  localparam int unsigned KEY_W     = DIST_W + 1;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [5:0]                 box_slot;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [EXT_W-1:0]           extent_x;
    logic [EXT_W-1:0]           extent_y;
    logic [EXT_W-1:0]           extent_z;
    logic signed [TRIG_W-1:0]   cos_yaw;
    logic signed [TRIG_W-1:0]   sin_yaw;
  } in_t;

  typedef struct packed {
    logic                       keep_point;
    logic [5:0]                 nearest_slot;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  cz;
    logic [EXT_W-1:0]           ex;
    logic [EXT_W-1:0]           ey;
    logic [EXT_W-1:0]           ez;
    logic signed [TRIG_W-1:0]   cs;
    logic signed [TRIG_W-1:0]   sn;
  } box_t;

  typedef struct packed {
    logic                       en;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } ctr_wr_t;

endpackage
`default_nettype wire

// ===== src/point_box_removal_filter.sv =====
// top level: box table, nearest box search and rotated box test pipeline
//
// channel   dir  handshake               payload
// in        in   in_valid_i/in_ready_o    pbrf_pkg::in_t
// out       out  out_valid_o/out_ready_i  pbrf_pkg::out_t
// cfg       in   cfg_valid_i/cfg_ready_o  box_count, 7 bits
//
// a point request enters every cycle unless the output stalls or a box_count write waits
// a load request waits until no point is in flight, then writes the table when accepted
// a box_count write waits until no point is in flight and holds off the input
// the latency is set by the 64 lane minimum tree and the rotate multiply
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset clears the valid bits and box_count only, the table is undefined
`default_nettype none
module point_box_removal_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pbrf_pkg::in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pbrf_pkg::out_t                      out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pbrf_pkg::CNT_W-1:0]     cfg_data_i
);
  import pbrf_pkg::*;

  localparam int unsigned NST = 8;
  localparam int unsigned PW  = TRIG_W + COORD_W;
  localparam int unsigned RW  = PW + 2;
  localparam int unsigned AW  = PW + 1;
  localparam int unsigned CW  = AW + 7;
  localparam int unsigned ZW  = COORD_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      none;
  } pt_t;

  logic [CNT_W-1:0]  cnt_q;
  logic [NST-1:0]    v_q;
  pt_t               pt_q [NST];
  logic [SLOT_W-1:0] idx5_q;
  logic [SLOT_W-1:0] idx6_q;
  logic [SLOT_W-1:0] idx7_q;
  logic [SLOT_W-1:0] idx_near;
  box_t              box_mem [MAX_BOXES];
  box_t              box_q;
  box_t              box7_q;
  logic signed [PW-1:0] pcx_q, psy_q, pcy_q, psx_q;
  logic [ZW-1:0]     adz_q;
  logic [AW-1:0]     adx_q, ady_q;
  logic [ZW-1:0]     adz8_q;
  logic [EXT_W-1:0]  ex8_q, ey8_q, ez8_q;
  logic              adv, busy, in_acc, ld_acc;
  ctr_wr_t           wr;
  out_t              out_q;
  logic              out_v_q;

  logic signed [RW-1:0] rx, ry, cxs, cys, ddx, ddy;
  logic signed [ZW-1:0] ddz;
  logic [CW-1:0]        lx, rxl, ly, ryl;
  logic [ZW+6:0]        lz, rzl;
  logic                 in_box;

  assign adv         = !out_v_q || out_ready_i;
  assign busy        = |v_q;
  assign in_ready_o  = adv && !cfg_valid_i && (in_data_i.op == OP_POINT || !busy);
  assign in_acc      = in_valid_i && in_ready_o;
  assign ld_acc      = in_acc && in_data_i.op == OP_LOAD;
  assign cfg_ready_o = !busy;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign wr.en   = ld_acc;
  assign wr.slot = in_data_i.box_slot;
  assign wr.x    = in_data_i.coord_x;
  assign wr.y    = in_data_i.coord_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_q <= cfg_data_i;
      end
      if (adv) begin
        v_q     <= {v_q[NST-2:0], in_acc && in_data_i.op == OP_POINT};
        out_v_q <= v_q[NST-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_acc) begin
      box_mem[in_data_i.box_slot] <= '{cx: in_data_i.coord_x, cy: in_data_i.coord_y,
                                       cz: in_data_i.coord_z, ex: in_data_i.extent_x,
                                       ey: in_data_i.extent_y, ez: in_data_i.extent_z,
                                       cs: in_data_i.cos_yaw, sn: in_data_i.sin_yaw};
    end
  end

  pbrf_nearest u_near (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .wr_i    (wr),
    .px_i    (pt_q[0].x),
    .py_i    (pt_q[0].y),
    .count_i (cnt_q),
    .idx_o   (idx_near)
  );

  // rotation differences and margin compare
  always_comb begin
    rx  = RW'(pcx_q) + RW'(psy_q);
    ry  = RW'(pcy_q) - RW'(psx_q);
    cxs = RW'(box7_q.cx) <<< 14;
    cys = RW'(box7_q.cy) <<< 14;
    ddx = rx - cxs;
    ddy = ry - cys;
    ddz = ZW'(pt_q[5].z) - ZW'(box_q.cz);
    lx  = (CW'(adx_q) << 4) + (CW'(adx_q) << 2);
    ly  = (CW'(ady_q) << 4) + (CW'(ady_q) << 2);
    rxl = (CW'(ex8_q) << 18) + (CW'(ex8_q) << 16) + (CW'(ex8_q) << 14);
    ryl = (CW'(ey8_q) << 18) + (CW'(ey8_q) << 16) + (CW'(ey8_q) << 14);
    lz  = ((ZW+7)'(adz8_q) << 4) + ((ZW+7)'(adz8_q) << 2);
    rzl = ((ZW+7)'(ez8_q) << 4) + ((ZW+7)'(ez8_q) << 2) + (ZW+7)'(ez8_q);
    in_box = (lx < rxl) && (ly < ryl) && (lz < rzl);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q[0] <= '{x: in_data_i.coord_x, y: in_data_i.coord_y, z: in_data_i.coord_z,
                   none: (cnt_q == '0)};
      for (int s = 1; s < NST; s++) begin
        pt_q[s] <= pt_q[s-1];
      end
      // stage 5 to 6: table read at the chosen slot
      box_q  <= box_mem[idx_near];
      idx5_q <= idx_near;
      // stage 6 to 7: rotation products
      pcx_q  <= PW'(box_q.cs) * PW'(pt_q[5].x);
      psy_q  <= PW'(box_q.sn) * PW'(pt_q[5].y);
      pcy_q  <= PW'(box_q.cs) * PW'(pt_q[5].y);
      psx_q  <= PW'(box_q.sn) * PW'(pt_q[5].x);
      adz_q  <= ddz[ZW-1] ? ZW'(-ddz) : ZW'(ddz);
      box7_q <= box_q;
      idx6_q <= idx5_q;
      // stage 7 to 8: absolute differences
      adx_q  <= ddx[RW-1] ? AW'(-ddx) : AW'(ddx);
      ady_q  <= ddy[RW-1] ? AW'(-ddy) : AW'(ddy);
      adz8_q <= adz_q;
      ex8_q  <= box7_q.ex;
      ey8_q  <= box7_q.ey;
      ez8_q  <= box7_q.ez;
      idx7_q <= idx6_q;
      // output register
      out_q.keep_point   <= pt_q[NST-1].none || !in_box;
      out_q.nearest_slot <= pt_q[NST-1].none ? '0 : idx7_q;
      out_q.out_x        <= pt_q[NST-1].x;
      out_q.out_y        <= pt_q[NST-1].y;
      out_q.out_z        <= pt_q[NST-1].z;
    end
  end

endmodule
`default_nettype wire

// ===== src/pbrf_nearest.sv =====
// nearest box center search: distance lanes and a registered minimum tree
`default_nettype none
module pbrf_nearest (
  input  wire logic                           clk_i,
  input  wire logic                           adv_i,
  input  wire pbrf_pkg::ctr_wr_t              wr_i,
  input  wire logic signed [pbrf_pkg::COORD_W-1:0] px_i,
  input  wire logic signed [pbrf_pkg::COORD_W-1:0] py_i,
  input  wire logic [pbrf_pkg::CNT_W-1:0]     count_i,
  output logic [pbrf_pkg::SLOT_W-1:0]         idx_o
);
  import pbrf_pkg::*;

  localparam int unsigned N3 = MAX_BOXES / 4;
  localparam int unsigned N4 = MAX_BOXES / 16;

  logic signed [COORD_W-1:0] ctr_x_q [MAX_BOXES];
  logic signed [COORD_W-1:0] ctr_y_q [MAX_BOXES];

  logic [KEY_W-1:0]  key2_q [MAX_BOXES];
  logic [KEY_W-1:0]  key2_d [MAX_BOXES];
  logic [KEY_W-1:0]  ka [MAX_BOXES/2];
  logic [SLOT_W-1:0] ia [MAX_BOXES/2];
  logic [KEY_W-1:0]  key3_d [N3];
  logic [SLOT_W-1:0] idx3_d [N3];
  logic [KEY_W-1:0]  key3_q [N3];
  logic [SLOT_W-1:0] idx3_q [N3];
  logic [KEY_W-1:0]  kb [N3/2];
  logic [SLOT_W-1:0] ib [N3/2];
  logic [KEY_W-1:0]  key4_d [N4];
  logic [SLOT_W-1:0] idx4_d [N4];
  logic [KEY_W-1:0]  key4_q [N4];
  logic [SLOT_W-1:0] idx4_q [N4];
  logic [KEY_W-1:0]  kc [N4/2];
  logic [SLOT_W-1:0] ic [N4/2];
  logic [SLOT_W-1:0] idx_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ctr_x_q[wr_i.slot] <= wr_i.x;
      ctr_y_q[wr_i.slot] <= wr_i.y;
    end
  end

  // one lane per box, disabled lanes sort last
  always_comb begin
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        ax;
    logic [COORD_W:0]        ay;
    for (int i = 0; i < MAX_BOXES; i++) begin
      dx = (COORD_W+1)'(ctr_x_q[i]) - (COORD_W+1)'(px_i);
      dy = (COORD_W+1)'(ctr_y_q[i]) - (COORD_W+1)'(py_i);
      ax = dx[COORD_W] ? COORD_W'(0) - dx : dx;
      ay = dy[COORD_W] ? COORD_W'(0) - dy : dy;
      key2_d[i] = {(32'(count_i) <= i), DIST_W'(ax) + DIST_W'(ay)};
    end
  end

  // lower index wins on a tie
  always_comb begin
    for (int i = 0; i < MAX_BOXES/2; i++) begin
      if (key2_q[2*i+1] < key2_q[2*i]) begin
        ka[i] = key2_q[2*i+1];
        ia[i] = SLOT_W'(2*i+1);
      end else begin
        ka[i] = key2_q[2*i];
        ia[i] = SLOT_W'(2*i);
      end
    end
    for (int i = 0; i < N3; i++) begin
      if (ka[2*i+1] < ka[2*i]) begin
        key3_d[i] = ka[2*i+1];
        idx3_d[i] = ia[2*i+1];
      end else begin
        key3_d[i] = ka[2*i];
        idx3_d[i] = ia[2*i];
      end
    end
    for (int i = 0; i < N3/2; i++) begin
      if (key3_q[2*i+1] < key3_q[2*i]) begin
        kb[i] = key3_q[2*i+1];
        ib[i] = idx3_q[2*i+1];
      end else begin
        kb[i] = key3_q[2*i];
        ib[i] = idx3_q[2*i];
      end
    end
    for (int i = 0; i < N4; i++) begin
      if (kb[2*i+1] < kb[2*i]) begin
        key4_d[i] = kb[2*i+1];
        idx4_d[i] = ib[2*i+1];
      end else begin
        key4_d[i] = kb[2*i];
        idx4_d[i] = ib[2*i];
      end
    end
    for (int i = 0; i < N4/2; i++) begin
      if (key4_q[2*i+1] < key4_q[2*i]) begin
        kc[i] = key4_q[2*i+1];
        ic[i] = idx4_q[2*i+1];
      end else begin
        kc[i] = key4_q[2*i];
        ic[i] = idx4_q[2*i];
      end
    end
    idx_d = (kc[1] < kc[0]) ? ic[1] : ic[0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key2_q <= key2_d;
      key3_q <= key3_d;
      idx3_q <= idx3_d;
      key4_q <= key4_d;
      idx4_q <= idx4_d;
      idx_o  <= idx_d;
    end
  end

endmodule
`default_nettype wire

// ===== tb/point_box_removal_filter_tb.sv =====
// testbench for the point box removal filter: scoreboard, stimulus and checks
`default_nettype none
module point_box_removal_filter_tb;
  import pbrf_pkg::*;

  class removal_scoreboard;
    logic [CNT_W-1:0] count_q;
    box_t             boxes[MAX_BOXES];
    out_t             pending[$];
    int               mismatches;

    function new();
      count_q    = '0;
      mismatches = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] c);
      count_q = c;
    endfunction

    function longint absl(longint v);
      return v < 0 ? -v : v;
    endfunction

    // apply a load or predict a point result
    function void note_request(in_t r);
      out_t    e;
      int      n, best;
      longint  px, py, pz, d, bd, rx, ry, dx, dy, dz;
      box_t    b;
      if (r.op == OP_LOAD) begin
        boxes[r.box_slot] = '{cx: r.coord_x, cy: r.coord_y, cz: r.coord_z,
                              ex: r.extent_x, ey: r.extent_y, ez: r.extent_z,
                              cs: r.cos_yaw, sn: r.sin_yaw};
        return;
      end
      px = r.coord_x; py = r.coord_y; pz = r.coord_z;
      e.out_x = r.coord_x; e.out_y = r.coord_y; e.out_z = r.coord_z;
      n = (count_q > MAX_BOXES) ? int'(MAX_BOXES) : int'(count_q);
      if (n == 0) begin
        e.keep_point = 1'b1;
        e.nearest_slot = '0;
      end else begin
        best = 0;
        bd = absl(longint'(boxes[0].cx) - px) + absl(longint'(boxes[0].cy) - py);
        for (int i = 1; i < n; i++) begin
          d = absl(longint'(boxes[i].cx) - px) + absl(longint'(boxes[i].cy) - py);
          if (d < bd) begin
            bd = d;
            best = i;
          end
        end
        b  = boxes[best];
        rx = longint'(b.cs) * px + longint'(b.sn) * py;
        ry = longint'(b.cs) * py - longint'(b.sn) * px;
        dx = absl(rx - longint'(b.cx) * 16384);
        dy = absl(ry - longint'(b.cy) * 16384);
        dz = absl(pz - longint'(b.cz));
        e.keep_point = !((dx * 20 < longint'(b.ex) * 16384 * 21) &&
                         (dy * 20 < longint'(b.ey) * 16384 * 21) &&
                         (dz * 20 < longint'(b.ez) * 21));
        e.nearest_slot = best[5:0];
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(out_t a);
      out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
        return;
      end
      e = pending.pop_front();
      if (a.keep_point !== e.keep_point || a.nearest_slot !== e.nearest_slot ||
          a.out_x !== e.out_x || a.out_y !== e.out_y || a.out_z !== e.out_z) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic             clk_i, rst_ni;
  logic             in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic             cfg_valid_i, cfg_ready_o;
  in_t              in_data_i;
  out_t             out_data_o;
  logic [CNT_W-1:0] cfg_data_i;

  removal_scoreboard sb = new();
  int  send_idle, recv_stall;
  bit  hold_off;

  point_box_removal_filter uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("point_box_removal_filter_tb: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
    if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send(in_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CNT_W-1:0] c);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_count(c);
  endtask

  function automatic in_t rand_point(bit nearby);
    in_t r;
    r = '0;
    r.op = OP_POINT;
    r.box_slot = SLOT_W'($urandom);
    r.extent_x = EXT_W'($urandom); r.extent_y = EXT_W'($urandom);
    r.extent_z = EXT_W'($urandom);
    r.cos_yaw = TRIG_W'($urandom); r.sin_yaw = TRIG_W'($urandom);
    if (nearby) begin
      r.coord_x = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      r.coord_y = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      r.coord_z = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    end else begin
      r.coord_x = $urandom; r.coord_y = $urandom; r.coord_z = $urandom;
    end
    return r;
  endfunction

  function automatic in_t rand_box(int slot, bit wild);
    in_t  r;
    int   k;
    r = rand_point(!wild);
    r.op = OP_LOAD;
    r.box_slot = SLOT_W'(slot);
    if (wild) begin
      r.extent_x = EXT_W'($urandom); r.extent_y = EXT_W'($urandom);
      r.extent_z = EXT_W'($urandom);
      r.cos_yaw = TRIG_W'($urandom_range(0, 32768) - 16384);
      r.sin_yaw = TRIG_W'($urandom_range(0, 32768) - 16384);
    end else begin
      r.extent_x = EXT_W'($urandom_range(0, 3 << 16));
      r.extent_y = EXT_W'($urandom_range(0, 3 << 16));
      r.extent_z = EXT_W'($urandom_range(0, 3 << 16));
      k = $urandom_range(3);
      // mostly axis aligned or simple yaws so rotated tests hit both sides
      case (k)
        0: begin r.cos_yaw = TRIG_W'(16384);  r.sin_yaw = '0;             end
        1: begin r.cos_yaw = '0;              r.sin_yaw = TRIG_W'(16384); end
        2: begin r.cos_yaw = TRIG_W'(-16384); r.sin_yaw = '0;             end
        default: begin
          r.cos_yaw = TRIG_W'($urandom_range(0, 32768) - 16384);
          r.sin_yaw = TRIG_W'($urandom_range(0, 32768) - 16384);
        end
      endcase
    end
    return r;
  endfunction

  task automatic load_box(in_t r);
    send(r);
  endtask

  initial begin
    in_t r;
    int  c, phase;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    send_idle   = 0;
    recv_stall  = 0;
    hold_off    = 1'b0;
    rst_ni      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no boxes: extremes of point fields
    r = '0; r.op = OP_POINT;
    send(r);
    r.coord_x = 32'sh7fffffff; r.coord_y = 32'sh80000000; r.coord_z = 32'sh7fffffff;
    r.box_slot = '1; r.extent_x = '1; r.extent_y = '1; r.extent_z = '1;
    r.cos_yaw = '1; r.sin_yaw = '1;
    send(r);

    // all slots with extreme and plain boxes
    for (int s = 0; s < MAX_BOXES; s++) load_box(rand_box(s, s % 4 == 3));
    r = '0; r.op = OP_LOAD; r.box_slot = '0;
    r.coord_x = 32'sh80000000; r.coord_y = 32'sh7fffffff; r.coord_z = 32'sh80000000;
    r.extent_x = '1; r.extent_y = '1; r.extent_z = '1;
    r.cos_yaw = TRIG_W'(-16384); r.sin_yaw = TRIG_W'(16384);
    load_box(r);
    // tie: slot 2 duplicates slot 1, lower index must win
    r = rand_box(1, 1'b0); load_box(r); r.box_slot = SLOT_W'(2); load_box(r);

    write_count(7'd127);
    r = '0; r.op = OP_POINT; r.coord_x = 32'sh80000000; r.coord_y = 32'sh7fffffff;
    send(r);
    for (int i = 0; i < 8; i++) send(rand_point(1));
    write_count(7'd3);
    for (int i = 0; i < 8; i++) send(rand_point(1));
    write_count(7'd1);
    send(rand_point(0));
    send(rand_point(1));

    // random phases
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      c = (phase == 5) ? 64 : (phase == 9) ? 0 : $urandom_range(1, 70);
      write_count(c[CNT_W-1:0]);
      if (phase == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(99) < 6) load_box(rand_box($urandom_range(0, 63),
                                                     $urandom_range(9) == 0));
        else send(rand_point($urandom_range(9) != 0));
      end
    end

    send_idle = 0;
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("point_box_removal_filter_tb: done, clean");
    else
      $display("point_box_removal_filter_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
